// ----- rtl/core/npc_pkg.sv -----
// npc_pkg: shared constants, codes and control types for the palette quantizer
// used by npc_ctrl, npc_datapath and nearest_palette_color; no dependencies
package npc_pkg;

  localparam int unsigned DepthDefault = 256;
  localparam int unsigned CH_W         = 8;   // bits per color channel
  localparam int unsigned IDX_PORT_W   = 8;   // entry_index / nearest_index width
  localparam int unsigned CFG_W        = 9;   // palette_entries register width
  localparam int unsigned SQ_W         = 16;  // one squared channel difference
  localparam int unsigned DIST_W       = 18;  // sum of three squares

  localparam logic [CFG_W-1:0] ENTRIES_RESET = 9'd16;

  // function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUANT = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_en;     // write one palette entry
    logic start;     // latch the color to quantize
    logic rd_en;     // read one entry for the scan
    logic rd_first;  // the read is entry 0
    logic rd_last;   // the read is the last entry searched
    logic load_out;  // copy best index into the output register
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

// ----- rtl/core/npc_ctrl.sv -----
// npc_ctrl: controller of the palette quantizer (handshakes, size register,
// scan address sequencing); depends on npc_pkg
module npc_ctrl #(
  parameter int unsigned PALETTE_DEPTH = npc_pkg::DepthDefault,
  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [npc_pkg::IDX_PORT_W-1:0]      entry_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_wr_en,
  input  logic [npc_pkg::CFG_W-1:0]           cfg_wr_data,
  output npc_pkg::cmd_t                       cmd,
  output logic [IDX_W-1:0]                    rd_addr,
  input  logic                                dp_done
);

  npc_pkg::state_t state, state_next;
  logic [npc_pkg::CFG_W-1:0] palette_entries;
  logic [IDX_W-1:0]          last_addr;
  logic [IDX_W-1:0]          last_addr_next;
  logic                      in_accept;
  logic                      slot_free;

  assign in_stall  = (state != npc_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // clamp size register to 1 .. PALETTE_DEPTH, keep last index
  always_comb begin
    if (palette_entries == '0) begin
      last_addr_next = '0;
    end else if (palette_entries > npc_pkg::CFG_W'(PALETTE_DEPTH)) begin
      last_addr_next = IDX_W'(PALETTE_DEPTH - 1);
    end else begin
      last_addr_next = IDX_W'(palette_entries - 9'd1);
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    cmd.wr_en    = in_accept && (func == npc_pkg::FUNC_LOAD) &&
                   ({1'b0, entry_index} < npc_pkg::CFG_W'(PALETTE_DEPTH));
    cmd.start    = in_accept && (func == npc_pkg::FUNC_QUANT);
    cmd.rd_en    = (state == npc_pkg::ST_SCAN);
    cmd.rd_first = (rd_addr == '0);
    cmd.rd_last  = (rd_addr == last_addr);
    cmd.load_out = (state == npc_pkg::ST_FINISH) && slot_free;
    case (state)
      npc_pkg::ST_IDLE: begin
        if (cmd.start) state_next = npc_pkg::ST_SCAN;
      end
      npc_pkg::ST_SCAN: begin
        if (cmd.rd_last) state_next = npc_pkg::ST_DRAIN;
      end
      npc_pkg::ST_DRAIN: begin
        if (dp_done) state_next = npc_pkg::ST_FINISH;
      end
      npc_pkg::ST_FINISH: begin
        if (slot_free) state_next = npc_pkg::ST_IDLE;
      end
      default: begin
        state_next = npc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= npc_pkg::ST_IDLE;
      palette_entries <= npc_pkg::ENTRIES_RESET;
      out_valid       <= 1'b0;
      rd_addr         <= '0;
      last_addr       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) palette_entries <= cfg_wr_data;
      if (cmd.start) begin
        rd_addr   <= '0;
        last_addr <= last_addr_next;
      end else if (cmd.rd_en && !cmd.rd_last) begin
        rd_addr <= rd_addr + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    dp_done |-> (state == npc_pkg::ST_DRAIN))
    else $error("datapath done outside drain");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result overwritten before taken");

  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (rd_addr <= last_addr))
    else $error("scan read past last entry");

  a_out_drops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !cmd.load_out) |=> !out_valid)
    else $error("result repeated");
`endif

endmodule

// ----- rtl/core/npc_datapath.sv -----
// npc_datapath: palette memory, squared distance pipeline and best tracker
// depends on npc_pkg; driven by npc_ctrl commands
module npc_datapath #(
  parameter int unsigned PALETTE_DEPTH = npc_pkg::DepthDefault,
  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  npc_pkg::cmd_t                     cmd,
  input  logic [IDX_W-1:0]                  rd_addr,
  input  logic [npc_pkg::IDX_PORT_W-1:0]    entry_index,
  input  logic [npc_pkg::CH_W-1:0]          red,
  input  logic [npc_pkg::CH_W-1:0]          green,
  input  logic [npc_pkg::CH_W-1:0]          blue,
  output logic                              dp_done,
  output logic [npc_pkg::IDX_PORT_W-1:0]    nearest_index
);

  localparam int unsigned ENT_W = 3 * npc_pkg::CH_W;

  logic [ENT_W-1:0]          mem [PALETTE_DEPTH];
  logic [ENT_W-1:0]          rd_data;
  logic [ENT_W-1:0]          color;

  logic                      s1_valid, s1_first, s1_last;
  logic [IDX_W-1:0]          s1_idx;
  logic                      s2_valid, s2_first, s2_last;
  logic [IDX_W-1:0]          s2_idx;
  logic [npc_pkg::SQ_W-1:0]  sq_r, sq_g, sq_b;
  logic [npc_pkg::CH_W-1:0]  d_r, d_g, d_b;
  logic [npc_pkg::DIST_W-1:0] dist_sum;
  logic [npc_pkg::DIST_W-1:0] best_d;
  logic [IDX_W-1:0]          best_idx;

  function automatic logic [npc_pkg::CH_W-1:0] abs_diff(
    input logic [npc_pkg::CH_W-1:0] a,
    input logic [npc_pkg::CH_W-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[entry_index[IDX_W-1:0]] <= {red, green, blue};
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  assign d_r  = abs_diff(rd_data[3*npc_pkg::CH_W-1:2*npc_pkg::CH_W],
                         color[3*npc_pkg::CH_W-1:2*npc_pkg::CH_W]);
  assign d_g  = abs_diff(rd_data[2*npc_pkg::CH_W-1:npc_pkg::CH_W],
                         color[2*npc_pkg::CH_W-1:npc_pkg::CH_W]);
  assign d_b  = abs_diff(rd_data[npc_pkg::CH_W-1:0], color[npc_pkg::CH_W-1:0]);
  assign dist_sum = npc_pkg::DIST_W'(sq_r) + npc_pkg::DIST_W'(sq_g) +
                    npc_pkg::DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (cmd.start) color <= {red, green, blue};
    s1_first <= cmd.rd_first;
    s1_last  <= cmd.rd_last;
    s1_idx   <= rd_addr;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_idx   <= s1_idx;
    sq_r     <= npc_pkg::SQ_W'(d_r) * npc_pkg::SQ_W'(d_r);
    sq_g     <= npc_pkg::SQ_W'(d_g) * npc_pkg::SQ_W'(d_g);
    sq_b     <= npc_pkg::SQ_W'(d_b) * npc_pkg::SQ_W'(d_b);
    // strict compare keeps the lowest index on ties
    if (s2_valid && (s2_first || dist_sum < best_d)) begin
      best_d   <= dist_sum;
      best_idx <= s2_idx;
    end
    if (cmd.load_out) nearest_index <= npc_pkg::IDX_PORT_W'(best_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      dp_done  <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
      dp_done  <= s2_valid && s2_last;
    end
  end

endmodule

// ----- rtl/core/nearest_palette_color.sv -----
// load: the entry is written when taken, the next item is taken in the following cycle
// quantize: the scan reads N = searched entries (1..PALETTE_DEPTH) through the single read
//   port of the palette memory, one entry per cycle, then 3 pipe stages; no new item is
//   taken until the result is loaded, but a new item is taken while a result waits
// reset (rst, synchronous): controller idle, no result pending, palette_entries = 16;
//   palette contents are not cleared and must be loaded before they are searched
// top level of the palette quantizer; depends on npc_pkg, npc_ctrl, npc_datapath
module nearest_palette_color #(
  parameter int unsigned PALETTE_DEPTH = npc_pkg::DepthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [npc_pkg::IDX_PORT_W-1:0]   entry_index,
  input  logic [npc_pkg::CH_W-1:0]         red,
  input  logic [npc_pkg::CH_W-1:0]         green,
  input  logic [npc_pkg::CH_W-1:0]         blue,
  // result item channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [npc_pkg::IDX_PORT_W-1:0]   nearest_index,
  // size register write port
  input  logic                             cfg_wr_en,
  input  logic [npc_pkg::CFG_W-1:0]        cfg_wr_data
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

  // controller to datapath commands and scan address
  npc_pkg::cmd_t    cmd;
  logic [IDX_W-1:0] rd_addr;
  // last distance compare done, best index final
  logic             dp_done;

  // sequencer: handshakes, size clamp, scan counter
  npc_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .entry_index(entry_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .dp_done    (dp_done)
  );

  // palette memory, distance pipe and running minimum
  npc_datapath #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .dp_done      (dp_done),
    .nearest_index(nearest_index)
  );

endmodule

// ----- verif/nearest_palette_color_tb.sv -----
`timescale 1ns / 1ps
// nearest_palette_color_tb: self-checking bench for the palette quantizer with its own
// nearest-color predictor, random idling on both channels and several size settings
// depends on npc_pkg and nearest_palette_color
module nearest_palette_color_tb;

  localparam int unsigned CH_W       = npc_pkg::CH_W;
  localparam int unsigned IDX_PORT_W = npc_pkg::IDX_PORT_W;
  localparam int unsigned CFG_W      = npc_pkg::CFG_W;
  localparam int unsigned DEPTH     = 256;
  localparam int unsigned IDLE_WAIT = 8;          // loads are written when taken, margin on top
  localparam int unsigned END_WAIT  = DEPTH + 8;  // longest scan plus the pipe stages
  localparam int unsigned MAX_GAP   = 10;
  localparam int unsigned RGB_W     = 3 * CH_W;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  func;
  logic [IDX_PORT_W-1:0] entry_index;
  logic [CH_W-1:0]       red;
  logic [CH_W-1:0]       green;
  logic [CH_W-1:0]       blue;
  logic                  out_valid;
  logic                  out_stall;
  logic [IDX_PORT_W-1:0] nearest_index;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;

  // bench copy of the palette and the size register
  logic [RGB_W-1:0]      palette_model [DEPTH];
  bit                    loaded [DEPTH];
  logic [CFG_W-1:0]      palette_size;
  // nearest indexes still owed by the block, oldest first
  logic [IDX_PORT_W-1:0] pending_nearest [$];

  bit          steady_flow = 1'b0;  // no idling on either side while set
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned loads_sent      = 0;
  int unsigned lookups_sent    = 0;
  int unsigned size_writes     = 0;

  nearest_palette_color #(
    .PALETTE_DEPTH(DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .nearest_index(nearest_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("timeout with %0d results still owed", pending_nearest.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // size register as the scan uses it: zero acts as one, large values saturate
  function automatic int unsigned searched_entries();
    if (palette_size == 0) return 1;
    if (palette_size > DEPTH) return DEPTH;
    return palette_size;
  endfunction

  function automatic int unsigned channel_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // strict less-than keeps the lowest index on equal distances
  function automatic logic [IDX_PORT_W-1:0] nearest_entry(logic [RGB_W-1:0] rgb);
    int unsigned           count;
    int unsigned           best_sq;
    int unsigned           d_sq;
    logic [IDX_PORT_W-1:0] best;
    count   = searched_entries();
    best    = '0;
    best_sq = '1;
    for (int unsigned i = 0; i < count; i++) begin
      d_sq = channel_sq(palette_model[i][2*CH_W +: CH_W], rgb[2*CH_W +: CH_W])
           + channel_sq(palette_model[i][CH_W +: CH_W], rgb[CH_W +: CH_W])
           + channel_sq(palette_model[i][0 +: CH_W], rgb[0 +: CH_W]);
      if (d_sq < best_sq) begin
        best_sq = d_sq;
        best    = IDX_PORT_W'(i);
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // valid stays high after the item is taken so a following send can go back to back;
  // a send with a gap drops it itself, anything else that waits drops it through drain_block
  task automatic send_item(logic f, logic [IDX_PORT_W-1:0] idx, logic [RGB_W-1:0] rgb);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              = 1'b1;
    func                  = f;
    entry_index           = idx;
    {red, green, blue}    = rgb;
    do @(posedge clk); while (in_stall !== 1'b0);
    // item taken at this edge
    if (f == npc_pkg::FUNC_LOAD) begin
      palette_model[idx] = rgb;
      loaded[idx]        = 1'b1;
      loads_sent++;
    end else begin
      pending_nearest.push_back(nearest_entry(rgb));
      lookups_sent++;
    end
  endtask

  // stop offering items, wait for every owed result, then let the block settle
  task automatic drain_block(int unsigned settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_W-1:0] value);
    drain_block(IDLE_WAIT);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    palette_size = value;
    size_writes++;
  endtask

  // load every entry below count that was never written, so no scan sees an unwritten one
  task automatic fill_palette(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      if (!loaded[i]) send_item(npc_pkg::FUNC_LOAD, IDX_PORT_W'(i), RGB_W'($urandom));
  endtask

  // lookup colors: uniform, channel extremes, exact entry copies, or near an entry
  function automatic logic [RGB_W-1:0] lookup_color(int unsigned span);
    logic [RGB_W-1:0] base;
    logic [RGB_W-1:0] rgb;
    int               c;
    base = palette_model[$urandom_range(0, span - 1)];
    rgb  = RGB_W'($urandom);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        for (int ch = 0; ch < 3; ch++)
          rgb[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      2: rgb = base;
      default: begin
        for (int ch = 0; ch < 3; ch++) begin
          c = int'(base[ch*CH_W +: CH_W]) + int'($urandom_range(0, 12)) - 6;
          c = (c < 0) ? 0 : (c > 255) ? 255 : c;
          rgb[ch*CH_W +: CH_W] = CH_W'(c);
        end
      end
    endcase
    return rgb;
  endfunction

  // one random item; span entries are all loaded, loads may land anywhere
  task automatic random_item(int unsigned span);
    logic [RGB_W-1:0] rgb;
    if ($urandom_range(0, 99) < 35) begin
      // some loads copy an entry in use so equal distances keep turning up
      if ($urandom_range(0, 3) == 0) rgb = palette_model[$urandom_range(0, span - 1)];
      else rgb = RGB_W'($urandom);
      send_item(npc_pkg::FUNC_LOAD, IDX_PORT_W'($urandom_range(0, DEPTH - 1)), rgb);
    end else begin
      send_item(npc_pkg::FUNC_QUANT, IDX_PORT_W'($urandom), lookup_color(span));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall per item, then compare with the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin : result_check
    int unsigned           hold;
    logic [IDX_PORT_W-1:0] want;
    out_stall = 1'b0;
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (rst || out_valid !== 1'b1);
      if (pending_nearest.size() == 0) begin
        report_mismatch($sformatf("nearest_index %0d with no lookup pending", nearest_index));
      end else begin
        want = pending_nearest.pop_front();
        if (nearest_index !== want)
          report_mismatch($sformatf("nearest_index got %0d want %0d", nearest_index, want));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset size of 16, black and white corners, pure primaries and duplicated entries
  task automatic test_reset_size_ties();
    logic [RGB_W-1:0] entries [16];
    logic [RGB_W-1:0] probes [6];
    entries = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                24'h0000FF, 24'hFF0000, 24'h808080, 24'hFFFF00,
                24'h00FFFF, 24'hFF00FF, 24'h400000, 24'h004000,
                24'h000040, 24'hC0C0C0, 24'h202020, 24'hFFFFFF};
    probes  = '{24'h000000, 24'hFFFFFF, 24'hFA0505, 24'h0000FF, 24'h818181, 24'h5A3CC3};
    for (int i = 0; i < 16; i++) send_item(npc_pkg::FUNC_LOAD, IDX_PORT_W'(i), entries[i]);
    foreach (probes[i]) send_item(npc_pkg::FUNC_QUANT, 8'hFF, probes[i]);
  endtask

  // size zero searches entry 0 only, same as size one
  task automatic test_size_floor();
    write_size(9'd0);
    send_item(npc_pkg::FUNC_QUANT, 8'h00, 24'hFFFFFF);
    send_item(npc_pkg::FUNC_QUANT, 8'h5A, 24'h000000);
    send_item(npc_pkg::FUNC_QUANT, 8'hA5, RGB_W'($urandom));
    write_size(9'd1);
    send_item(npc_pkg::FUNC_QUANT, 8'h00, 24'hFF0000);
    send_item(npc_pkg::FUNC_QUANT, 8'hFF, RGB_W'($urandom));
  endtask

  // phases of mixed loads and lookups at modest sizes
  task automatic test_random_phases();
    int unsigned sz;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: sz = 2;
        1: sz = $urandom_range(3, 48);
        2: sz = 16;
        3: sz = $urandom_range(1, 64);
        4: sz = 31;
        default: sz = $urandom_range(17, 100);
      endcase
      write_size(CFG_W'(sz));
      fill_palette(searched_entries());
      repeat (22) random_item(searched_entries());
    end
  endtask

  // whole palette searched, sizes past the depth that must saturate, and one just below
  task automatic test_full_palette();
    logic [CFG_W-1:0] sizes [4];
    sizes = '{9'd256, 9'd511, 9'd257, 9'd255};
    fill_palette(DEPTH);
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      repeat (5) random_item(searched_entries());
    end
  endtask

  // no idling on either channel
  task automatic test_back_to_back();
    write_size(9'd12);
    steady_flow = 1'b1;
    repeat (40) random_item(12);
    drain_block(IDLE_WAIT);
    steady_flow = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = npc_pkg::FUNC_LOAD;
    entry_index  = '0;
    red          = '0;
    green        = '0;
    blue         = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    palette_size = npc_pkg::ENTRIES_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_size_ties();
    test_size_floor();
    test_random_phases();
    test_full_palette();
    test_back_to_back();

    drain_block(END_WAIT);
    $display("covered %0d entry loads and %0d color lookups, %0d results compared",
             loads_sent, lookups_sent, results_checked);
    $display("over %0d size writes from 0 to 511 with random and back-to-back idling",
             size_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- nearest_palette_color.f -----
rtl/core/npc_pkg.sv
rtl/core/npc_ctrl.sv
rtl/core/npc_datapath.sv
rtl/core/nearest_palette_color.sv
verif/nearest_palette_color_tb.sv
